/* hw/rtl/ptsri_pkg.sv */
// ----------------------------------------------------------------------------
// ptsri_pkg
// Shared types and constants of the pan/tilt servo rate integrator.
// ----------------------------------------------------------------------------
package ptsri_pkg;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	// register indexes
	localparam logic [CfgIndexW-1:0] REG_PAN_CENTER  = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_TILT_CENTER = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_TRAVEL      = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_PERIOD      = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_TIMEOUT     = 3'd4;

	// register reset values
	localparam logic [15:0] CENTER_RST  = 16'd23040;
	localparam logic [13:0] TRAVEL_RST  = 14'd6434;
	localparam logic [15:0] PERIOD_RST  = 16'd3277;
	localparam logic [15:0] TIMEOUT_RST = 16'd10;

	// command modes
	localparam logic [1:0] MODE_POS  = 2'd0;
	localparam logic [1:0] MODE_RATE = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// angle and count arithmetic
	localparam logic signed [37:0] DEG_PER_LSB = 38'sd3754936;  // 180/pi/16, Q.20
	localparam logic [35:0] ANGLE_MAX  = 36'd48318382080;       // 180 deg, 2^-28 units
	localparam logic [30:0] COUNT_OFS  = 31'd370440000;         // base plus half divisor
	localparam logic [49:0] RECIP_MUL  = 50'd305419;            // floor(2^40 / 3600000)
	localparam logic [31:0] COUNT_DIV  = 32'd3600000;

	typedef struct packed {
		logic sample;     // latch rate * period
		logic apply;      // update position and rate
		logic load_pos;
		logic load_rate;
		logic stop;
		logic move;
	} lane_cmd_t;

	typedef struct packed {
		logic        speed_nz;
		logic        done;
		logic [11:0] count;
		logic [14:0] position;
	} lane_stat_t;

endpackage

/* hw/rtl/ptsri_lane.sv */
// ----------------------------------------------------------------------------
// ptsri_lane
// One servo axis: position and rate state, rate integration with travel
// clamp, and a five-stage pipeline from position to PWM off count.
// ----------------------------------------------------------------------------
module ptsri_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptsri_pkg::lane_cmd_t   cmd,
	input  logic signed [15:0]     value,
	input  logic [15:0]            center,
	input  logic [13:0]            travel,
	input  logic [15:0]            period,
	output ptsri_pkg::lane_stat_t  stat
);

	function automatic logic signed [14:0] clamp_travel(input logic signed [18:0] v,
			input logic [13:0] lim);
		logic signed [18:0] hi;
		logic signed [18:0] lo;
		logic signed [18:0] r;
		hi = $signed({5'b0, lim});
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[14:0];
	endfunction

	logic signed [14:0] angle_q;
	logic signed [15:0] speed_q;
	logic signed [32:0] prod_q;

	logic [32:0]        mag;
	logic [32:0]        mag_rnd;
	logic [18:0]        dmag;
	logic signed [18:0] delta;
	logic signed [18:0] sum;

	// integration step, rounded to nearest with ties away from zero
	always_comb begin
		mag     = prod_q[32] ? 33'(-prod_q) : prod_q;
		mag_rnd = mag + 33'd32768;
		dmag    = {2'b0, mag_rnd[32:16]};
		delta   = prod_q[32] ? -$signed(dmag) : $signed(dmag);
		sum     = $signed({{4{angle_q[14]}}, angle_q}) + delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			speed_q <= '0;
		end else if (cmd.apply) begin
			if (cmd.load_pos) begin
				angle_q <= clamp_travel({{3{value[15]}}, value}, travel);
			end else if (cmd.move) begin
				angle_q <= clamp_travel(sum, travel);
			end
			if (cmd.load_rate) begin
				speed_q <= value;
			end else if (cmd.stop) begin
				speed_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			prod_q <= $signed({{17{speed_q[15]}}, speed_q}) * $signed({17'b0, period});
		end
	end

	// count pipeline
	logic        start_q;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [37:0] aprod_s1;
	logic [35:0] ang_s2;
	logic [30:0] x_s3;
	logic [30:0] x_s4;
	logic [9:0]  q_s4;
	logic [11:0] count_s5;

	logic signed [38:0] asum;
	logic [46:0]        xprod;
	logic [49:0]        qprod;
	logic [31:0]        qback;
	logic [31:0]        rem;

	always_comb begin
		asum  = $signed({3'b0, center, 20'b0}) + $signed({aprod_s1[37], aprod_s1});
		xprod = {11'b0, ang_s2} * 47'd1900;
		qprod = {19'b0, x_s3} * ptsri_pkg::RECIP_MUL;
		qback = {22'b0, q_s4} * ptsri_pkg::COUNT_DIV;
		rem   = {1'b0, x_s4} - qback;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
		end else begin
			start_q <= cmd.apply;
			vld_s1  <= start_q;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			aprod_s1 <= $signed({{23{angle_q[14]}}, angle_q}) * ptsri_pkg::DEG_PER_LSB;
		end
		if (vld_s1) begin
			if (asum < 0) begin
				ang_s2 <= '0;
			end else if (asum > $signed({3'b0, ptsri_pkg::ANGLE_MAX})) begin
				ang_s2 <= ptsri_pkg::ANGLE_MAX;
			end else begin
				ang_s2 <= asum[35:0];
			end
		end
		if (vld_s2) begin
			x_s3 <= xprod[46:16] + ptsri_pkg::COUNT_OFS;
		end
		if (vld_s3) begin
			x_s4 <= x_s3;
			q_s4 <= qprod[49:40];
		end
		if (vld_s4) begin
			// reciprocal estimate is low by at most one
			count_s5 <= {2'b0, q_s4} + ((rem >= ptsri_pkg::COUNT_DIV) ? 12'd1 : 12'd0);
		end
	end

	assign stat.speed_nz = (speed_q != '0);
	assign stat.done     = vld_s5;
	assign stat.count    = count_s5;
	assign stat.position = angle_q;

endmodule

/* hw/rtl/ptsri_merge.sv */
// ----------------------------------------------------------------------------
// ptsri_merge
// Joins the two lane results and the drive flag into the output register.
// ----------------------------------------------------------------------------
module ptsri_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptsri_pkg::lane_stat_t pan_stat,
	input  ptsri_pkg::lane_stat_t tilt_stat,
	input  logic                  drive,
	input  logic                  load,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [11:0]           pan_count,
	output logic [11:0]           tilt_count,
	output logic signed [14:0]    pan_position,
	output logic signed [14:0]    tilt_position,
	output logic                  drive_update
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pan_count     <= pan_stat.count;
			tilt_count    <= tilt_stat.count;
			pan_position  <= $signed(pan_stat.position);
			tilt_position <= $signed(tilt_stat.position);
			drive_update  <= drive;
		end
	end

endmodule

/* hw/rtl/pan_tilt_servo_rate_integrator_core.sv */
// ----------------------------------------------------------------------------
// pan_tilt_servo_rate_integrator_core
// Two-axis servo controller: position and rate commands, tick-driven rate
// integration with timeout, and PWM off counts for both servos.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-------------
//  in      | mode, pan_value, tilt_value, pan_present,        | in_valid /
//          | tilt_present                                     | in_ready
//  out     | pan_count, tilt_count, pan_position,             | out_valid /
//          | tilt_position, drive_update                      | out_ready
//  cfg     | cfg_index, cfg_data                              | cfg_write
//
//  After its input is accepted, a result passes these registered steps in
//  order: form rate*period, update state, each lane's count pipeline (angle
//  multiply, clamp, scale, reciprocal, correction), then load the output.
//  in_ready is high only in IDLE, from the cycle after that load, so a new
//  command is taken only once the previous result is loaded. A result that
//  finds the output register still full waits in HOLD. Async reset clears state and restores config defaults.
// ----------------------------------------------------------------------------
module pan_tilt_servo_rate_integrator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [ptsri_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [ptsri_pkg::CfgDataW-1:0]      cfg_data,
	// input transactions
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          mode,
	input  logic signed [15:0]                  pan_value,
	input  logic signed [15:0]                  tilt_value,
	input  logic                                pan_present,
	input  logic                                tilt_present,
	// result transactions
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [11:0]                         pan_count,
	output logic [11:0]                         tilt_count,
	output logic signed [14:0]                  pan_position,
	output logic signed [14:0]                  tilt_position,
	output logic                                drive_update
);

	typedef enum logic [1:0] {
		IDLE,
		APPLY,
		WAIT,
		HOLD
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] pan_center_q;
	logic [15:0] tilt_center_q;
	logic [13:0] travel_q;
	logic [15:0] period_q;
	logic [15:0] timeout_q;

	// latched transaction
	logic [1:0]         mode_q;
	logic signed [15:0] pan_value_q;
	logic signed [15:0] tilt_value_q;
	logic               pan_present_q;
	logic               tilt_present_q;

	logic [15:0] ticks_q;
	logic        expire_q;
	logic        drive_q;

	logic [15:0] ticks_inc;
	logic        accept;
	logic        move;
	logic        free;
	logic        load;

	ptsri_pkg::lane_cmd_t  pan_cmd, tilt_cmd;
	ptsri_pkg::lane_stat_t pan_stat, tilt_stat;

	assign in_ready  = (state_q == IDLE);
	assign accept    = in_valid && in_ready;
	assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

	// a tick moves only if the timeout did not fire and some rate is set
	assign move = (mode_q == ptsri_pkg::MODE_TICK) && !expire_q
		&& (pan_stat.speed_nz || tilt_stat.speed_nz);

	assign load = ((state_q == WAIT) && pan_stat.done && free)
		|| ((state_q == HOLD) && free);

	always_comb begin
		pan_cmd.sample    = accept;
		pan_cmd.apply     = (state_q == APPLY);
		pan_cmd.load_pos  = (mode_q == ptsri_pkg::MODE_POS) && pan_present_q;
		pan_cmd.load_rate = (mode_q == ptsri_pkg::MODE_RATE);
		pan_cmd.stop      = (mode_q == ptsri_pkg::MODE_POS)
			|| ((mode_q == ptsri_pkg::MODE_TICK) && expire_q);
		pan_cmd.move      = move;
		tilt_cmd          = pan_cmd;
		tilt_cmd.load_pos = (mode_q == ptsri_pkg::MODE_POS) && tilt_present_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			pan_center_q   <= ptsri_pkg::CENTER_RST;
			tilt_center_q  <= ptsri_pkg::CENTER_RST;
			travel_q       <= ptsri_pkg::TRAVEL_RST;
			period_q       <= ptsri_pkg::PERIOD_RST;
			timeout_q      <= ptsri_pkg::TIMEOUT_RST;
			ticks_q        <= '0;
			expire_q       <= 1'b0;
			drive_q        <= 1'b0;
			mode_q         <= '0;
			pan_value_q    <= '0;
			tilt_value_q   <= '0;
			pan_present_q  <= 1'b0;
			tilt_present_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ptsri_pkg::REG_PAN_CENTER:  pan_center_q  <= cfg_data;
					ptsri_pkg::REG_TILT_CENTER: tilt_center_q <= cfg_data;
					ptsri_pkg::REG_TRAVEL:      travel_q      <= cfg_data[13:0];
					ptsri_pkg::REG_PERIOD:      period_q      <= cfg_data;
					ptsri_pkg::REG_TIMEOUT:     timeout_q     <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				IDLE: begin
					if (accept) begin
						mode_q         <= mode;
						pan_value_q    <= pan_value;
						tilt_value_q   <= tilt_value;
						pan_present_q  <= pan_present;
						tilt_present_q <= tilt_present;
						expire_q       <= 1'b0;
						if (mode == ptsri_pkg::MODE_RATE) begin
							ticks_q <= '0;
						end else if (mode == ptsri_pkg::MODE_TICK) begin
							ticks_q  <= ticks_inc;
							expire_q <= (ticks_inc > timeout_q);
						end
						state_q <= APPLY;
					end
				end
				APPLY: begin
					drive_q <= (mode_q == ptsri_pkg::MODE_POS) || move;
					state_q <= WAIT;
				end
				WAIT: begin
					if (pan_stat.done) begin
						state_q <= free ? IDLE : HOLD;
					end
				end
				HOLD: begin
					if (free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	ptsri_lane u_pan_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pan_cmd),
		.value  (pan_value_q),
		.center (pan_center_q),
		.travel (travel_q),
		.period (period_q),
		.stat   (pan_stat)
	);

	ptsri_lane u_tilt_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tilt_cmd),
		.value  (tilt_value_q),
		.center (tilt_center_q),
		.travel (travel_q),
		.period (period_q),
		.stat   (tilt_stat)
	);

	ptsri_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.pan_stat      (pan_stat),
		.tilt_stat     (tilt_stat),
		.drive         (drive_q),
		.load          (load),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pan_count     (pan_count),
		.tilt_count    (tilt_count),
		.pan_position  (pan_position),
		.tilt_position (tilt_position),
		.drive_update  (drive_update)
	);

endmodule

/* verif/pan_tilt_servo_rate_integrator_core_tb.sv */
// ----------------------------------------------------------------------------
// pan_tilt_servo_rate_integrator_core_tb
// Self-checking bench for the two-axis servo core. Commands go in through a
// bursty sender and results come out to a receiver that stalls on its own
// pattern. Every result is checked field by field against a cycle-free
// model of the positions, rates, timeout count and PWM count math.
// ----------------------------------------------------------------------------
module pan_tilt_servo_rate_integrator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;   // decodes to nothing

	localparam int SETTLE_CYCLES = 16;           // idle wait after the last result comes back
	localparam int QUIET_LIMIT   = 2000;         // cycles with no transaction

	// count math: angle in 2^-28 degree, pulse 500..2400 us over 20 ms
	localparam longint DEG_SCALE_Q20 = 64'sd3754936;
	localparam longint ANGLE_TOP     = longint'(180 * 256) << 20;
	localparam longint PULSE_BASE    = longint'(90000) << 28;
	localparam longint PULSE_DIV     = longint'(3600000) * 65536;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] pan_value;
		logic signed [15:0] tilt_value;
		logic               pan_present;
		logic               tilt_present;
	} servo_cmd_t;

	typedef struct packed {
		logic [11:0]        pan_count;
		logic [11:0]        tilt_count;
		logic signed [14:0] pan_position;
		logic signed [14:0] tilt_position;
		logic               drive_update;
	} servo_drive_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                            cfg_write = 1'b0;
	logic [ptsri_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [ptsri_pkg::CfgDataW-1:0]  cfg_data  = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	servo_cmd_t  in_item  = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [11:0]        pan_count;
	logic [11:0]        tilt_count;
	logic signed [14:0] pan_position;
	logic signed [14:0] tilt_position;
	logic               drive_update;

	// stimulus and scoreboard
	servo_cmd_t   command_fifo[$];
	servo_drive_t predicted_drives[$];
	int           commands_queued = 0;
	int           drives_seen     = 0;
	int           error_count     = 0;
	int           quiet_cycles    = 0;
	bit           brisk           = 1'b0;   // no gaps, no stalls

	// shadow of the core: config registers
	logic [15:0] pan_zero_m  = ptsri_pkg::CENTER_RST;
	logic [15:0] tilt_zero_m = ptsri_pkg::CENTER_RST;
	logic [13:0] travel_m    = ptsri_pkg::TRAVEL_RST;
	logic [15:0] period_m    = ptsri_pkg::PERIOD_RST;
	logic [15:0] timeout_m   = ptsri_pkg::TIMEOUT_RST;

	// shadow of the core: axis state
	logic signed [15:0] pan_pos_m   = '0;
	logic signed [15:0] tilt_pos_m  = '0;
	logic signed [15:0] pan_rate_m  = '0;
	logic signed [15:0] tilt_rate_m = '0;
	logic [15:0]        rate_age_m  = '0;

	pan_tilt_servo_rate_integrator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (in_item.mode),
		.pan_value     (in_item.pan_value),
		.tilt_value    (in_item.tilt_value),
		.pan_present   (in_item.pan_present),
		.tilt_present  (in_item.tilt_present),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pan_count     (pan_count),
		.tilt_count    (tilt_count),
		.pan_position  (pan_position),
		.tilt_position (tilt_position),
		.drive_update  (drive_update)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Servo math
	// ------------------------------------------------------------------------

	// symmetric clamp to +/- travel
	function automatic logic signed [15:0] clamp_to_travel(longint v);
		longint lim;
		longint r;
		lim = travel_m;
		r = v;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		return r[15:0];
	endfunction

	// rate * period (Q3.28) back to Q3.12, nearest, ties away from zero
	function automatic longint rate_step(logic signed [15:0] rate);
		longint r;
		longint per;
		longint p;
		r = rate;
		per = period_m;
		p = r * per;
		if (p >= 0)
			return (p + 32768) / 65536;
		return -((-p + 32768) / 65536);
	endfunction

	// PWM off count for one servo at a given center and position
	function automatic logic [11:0] servo_off_count(logic [15:0] center,
			logic signed [15:0] pos);
		longint c;
		longint p;
		longint a;
		longint n;
		c = center;
		p = pos;
		a = (c <<< 20) + p * DEG_SCALE_Q20;
		if (a < 0)
			a = 0;
		if (a > ANGLE_TOP)
			a = ANGLE_TOP;
		n = (PULSE_BASE + 1900 * a + PULSE_DIV / 2) / PULSE_DIV;
		return n[11:0];
	endfunction

	// advance the shadow state by one command and return the drive it gives
	function automatic servo_drive_t predict_drive(servo_cmd_t c);
		servo_drive_t r;
		logic drove;
		drove = 1'b0;
		case (c.mode)
			ptsri_pkg::MODE_POS: begin
				if (c.pan_present)
					pan_pos_m = clamp_to_travel(longint'(c.pan_value));
				if (c.tilt_present)
					tilt_pos_m = clamp_to_travel(longint'(c.tilt_value));
				pan_rate_m = '0;
				tilt_rate_m = '0;
				drove = 1'b1;
			end
			ptsri_pkg::MODE_RATE: begin
				pan_rate_m = c.pan_value;
				tilt_rate_m = c.tilt_value;
				rate_age_m = '0;
			end
			ptsri_pkg::MODE_TICK: begin
				if (rate_age_m != 16'hFFFF)
					rate_age_m = rate_age_m + 16'd1;
				if (rate_age_m > timeout_m) begin
					pan_rate_m = '0;
					tilt_rate_m = '0;
				end
				if (pan_rate_m != 0 || tilt_rate_m != 0) begin
					pan_pos_m = clamp_to_travel(longint'(pan_pos_m) + rate_step(pan_rate_m));
					tilt_pos_m = clamp_to_travel(longint'(tilt_pos_m) + rate_step(tilt_rate_m));
					drove = 1'b1;
				end
			end
			default: ;
		endcase
		r.pan_count = servo_off_count(pan_zero_m, pan_pos_m);
		r.tilt_count = servo_off_count(tilt_zero_m, tilt_pos_m);
		r.pan_position = pan_pos_m[14:0];
		r.tilt_position = tilt_pos_m[14:0];
		r.drive_update = drove;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic send(logic [1:0] mode_i, logic signed [15:0] pv,
			logic signed [15:0] tv, logic pp, logic tp);
		servo_cmd_t c;
		c.mode = mode_i;
		c.pan_value = pv;
		c.tilt_value = tv;
		c.pan_present = pp;
		c.tilt_present = tp;
		command_fifo.push_back(c);
		commands_queued++;
	endtask

	// register write; takes effect at the edge after the one it starts on
	task automatic write_reg(logic [ptsri_pkg::CfgIndexW-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			ptsri_pkg::REG_PAN_CENTER:  pan_zero_m = val;
			ptsri_pkg::REG_TILT_CENTER: tilt_zero_m = val;
			ptsri_pkg::REG_TRAVEL:      travel_m = val[13:0];
			ptsri_pkg::REG_PERIOD:      period_m = val;
			ptsri_pkg::REG_TIMEOUT:     timeout_m = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [15:0] pc, logic [15:0] tc, logic [15:0] tr,
			logic [15:0] per, logic [15:0] tmo);
		write_reg(ptsri_pkg::REG_PAN_CENTER, pc);
		write_reg(ptsri_pkg::REG_TILT_CENTER, tc);
		write_reg(ptsri_pkg::REG_TRAVEL, tr);
		write_reg(ptsri_pkg::REG_PERIOD, per);
		write_reg(ptsri_pkg::REG_TIMEOUT, tmo);
	endtask

	// wait for every queued command to come back, then let the pipe drain
	task automatic settle();
		while (drives_seen != commands_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// position or rate value: full range with extra weight on the edges
	function automatic logic signed [15:0] pick_value();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: case ($urandom_range(0, 4))
				0: v = 16'h7FFF;
				1: v = 16'h8000;
				2: v = 16'h0000;
				3: v = 16'h0001;
				default: v = 16'hFFFF;
			endcase
			1: v = 16'($urandom_range(0, 600)) - 16'd300;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// rates mostly moderate so runs of ticks travel before hitting the clamp
	function automatic logic signed [15:0] pick_rate();
		if ($urandom_range(0, 3) == 0)
			return pick_value();
		return 16'($urandom_range(0, 8191)) - 16'd4096;
	endfunction

	// mostly rate commands followed by tick runs, with positions, stray
	// ticks, unused modes and interrupted runs mixed in
	task automatic queue_random(int n);
		int made;
		int k;
		int run_max;
		made = 0;
		while (made < n) begin
			run_max = (timeout_m < 24) ? int'(timeout_m) + 4 : 28;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					send(ptsri_pkg::MODE_RATE, pick_rate(), pick_rate(),
						1'($urandom), 1'($urandom));
					k = $urandom_range(1, run_max);
					repeat (k) send(ptsri_pkg::MODE_TICK, pick_value(), pick_value(),
						1'($urandom), 1'($urandom));
					made += k + 1;
				end
				5, 6: begin
					send(ptsri_pkg::MODE_POS, pick_value(), pick_value(),
						1'($urandom), 1'($urandom));
					made++;
				end
				7: begin
					k = $urandom_range(1, 4);
					repeat (k) send(ptsri_pkg::MODE_TICK, 16'($urandom), 16'($urandom),
						1'($urandom), 1'($urandom));
					made += k;
				end
				8: begin
					// leaves the core state unchanged, not counted in made
					send(MODE_UNUSED, 16'($urandom), 16'($urandom),
						1'($urandom), 1'($urandom));
				end
				default: begin
					// rate run cut short by a position command
					send(ptsri_pkg::MODE_RATE, pick_rate(), pick_rate(), 1'b0, 1'b0);
					send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
					send(ptsri_pkg::MODE_POS, pick_value(), pick_value(),
						1'($urandom), 1'($urandom));
					send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
					made += 4;
				end
			endcase
		end
	endtask

	task automatic flag_error(string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps. The payload
	// holds while valid is up; prediction is made at the accepting edge.
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin : sender
		servo_cmd_t nxt;
		logic nv;
		logic took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			took = in_valid && in_ready;
			if (took)
				predicted_drives.push_back(predict_drive(in_item));
			nv = in_valid && !took;
			nxt = in_item;
			if (!nv) begin
				if (gap_left != 0 && !brisk) begin
					gap_left <= gap_left - 1;
				end else if (command_fifo.size() != 0) begin
					nxt = command_fifo.pop_front();
					nv = 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			in_valid <= nv;
			in_item <= nxt;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: ready follows the bits of a 32-bit pattern, reloaded each lap.
	// Some laps are all ones so long stall-free stretches occur.
	// ------------------------------------------------------------------------
	logic [31:0] ready_pattern = '1;
	logic [4:0]  pattern_bit   = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_pattern <= '1;
			pattern_bit <= '0;
		end else begin
			out_ready <= brisk ? 1'b1 : ready_pattern[pattern_bit];
			pattern_bit <= pattern_bit + 5'd1;
			if (pattern_bit == 5'd31) begin
				case ($urandom_range(0, 3))
					0: ready_pattern <= '1;
					1: ready_pattern <= $urandom | 32'h1;
					2: ready_pattern <= $urandom | $urandom;
					default: ready_pattern <= {16'h0000, 16'hFFFF};
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		servo_drive_t want;
		if (arst_n && out_valid && out_ready) begin
			drives_seen++;
			if (predicted_drives.size() == 0) begin
				flag_error("result transaction with no command outstanding");
			end else begin
				want = predicted_drives.pop_front();
				check_field("pan_count", 16'(pan_count), 16'(want.pan_count));
				check_field("tilt_count", 16'(tilt_count), 16'(want.tilt_count));
				check_field("pan_position", 16'(pan_position), 16'(want.pan_position));
				check_field("tilt_position", 16'(tilt_position), 16'(want.tilt_position));
				check_field("drive_update", 16'(drive_update), 16'(want.drive_update));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any transaction or register write restarts the count
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("[pan_tilt_servo_rate_integrator_core] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: travel pi/2, period 0.05 s, timeout 10
		send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);                 // counts, no drive
		send(MODE_UNUSED, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);            // no state change
		send(ptsri_pkg::MODE_POS, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);    // clamp both
		send(ptsri_pkg::MODE_POS, 16'sd1234, -16'sd1234, 1'b0, 1'b0);   // no axis given
		send(ptsri_pkg::MODE_POS, 16'sd1000, '0, 1'b1, 1'b0);
		send(ptsri_pkg::MODE_POS, '0, -16'sd1000, 1'b0, 1'b1);
		send(ptsri_pkg::MODE_RATE, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);   // full-scale rates
		repeat (4) send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);      // run into the clamp
		send(ptsri_pkg::MODE_RATE, -16'sd1, 16'sd1, 1'b1, 1'b1);        // step rounds to 0
		repeat (12) send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);     // rates drop on 11th
		send(ptsri_pkg::MODE_POS, '0, '0, 1'b1, 1'b1);
		settle();

		// extremes one way: wide travel, longest period, timeout of zero
		load_settings(16'd0, 16'd46080, 16'd16383, 16'd65535, 16'd0);
		send(ptsri_pkg::MODE_POS, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);    // travel above range
		send(ptsri_pkg::MODE_RATE, 16'sd100, -16'sd100, 1'b0, 1'b0);
		repeat (2) send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
		queue_random(200);
		settle();

		// extremes the other way: centers past 180 deg and zero, no travel
		load_settings(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'hFFFF);
		queue_random(120);
		settle();

		// half-LSB steps: rounding ties go away from zero
		load_settings(16'd23040, 16'd23040, 16'd12868, 16'd32768, 16'd5);
		send(ptsri_pkg::MODE_RATE, 16'sd1, -16'sd1, 1'b0, 1'b0);
		send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
		send(ptsri_pkg::MODE_RATE, 16'sd3, -16'sd3, 1'b0, 1'b0);
		send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
		queue_random(150);
		settle();

		// zero period: nonzero rates still drive, positions hold; sent back to back
		brisk = 1'b1;
		write_reg(ptsri_pkg::REG_PERIOD, 16'd0);
		send(ptsri_pkg::MODE_RATE, 16'sd500, -16'sd500, 1'b0, 1'b0);
		repeat (3) send(ptsri_pkg::MODE_TICK, '0, '0, 1'b0, 1'b0);
		settle();
		brisk = 1'b0;

		repeat (6) begin
			load_settings(16'($urandom_range(0, 46080)), 16'($urandom_range(0, 46080)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
					: $urandom_range(200, 12868)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
					: $urandom_range(1, 8000)),
				16'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 20)));
			queue_random(180);
			settle();
		end

		if (error_count == 0)
			$display("[pan_tilt_servo_rate_integrator_core] OK");
		else
			$display("[pan_tilt_servo_rate_integrator_core] ERROR");
		$finish;
	end

endmodule
